FILE: src/nss_pkg.sv
package nss_pkg;

    // Field widths fixed by the interface
    localparam int CoordW  = 16;
    localparam int IdW     = 12;
    localparam int GroupW  = 2;
    localparam int DistW   = 16;
    localparam int CfgIdxW = 2;

    // Defaults for the top-level parameters
    localparam int GROUPS_DEF  = 4;
    localparam int ID_BITS_DEF = 12;

    localparam logic [DistW-1:0] DIST_MAX = '1;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_QUERY_X      = 2'd0,
        CFG_QUERY_Y      = 2'd1,
        CFG_ACTIVE_GROUP = 2'd2
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_L2A,
        S_L2B,
        S_DOTA,
        S_DOTB,
        S_DOT,
        S_CHK,
        S_DIV,
        S_PXA,
        S_PXB,
        S_PYA,
        S_SQA,
        S_SQB,
        S_SUM,
        S_RSTART,
        S_ROOT,
        S_UPD,
        S_FIN
    } t_state;

endpackage

FILE: src/nss_sqrt.sv
module nss_sqrt
    import nss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2*DistW-1:0] i_radicand,
    output logic               o_done,
    output logic [DistW-1:0]   o_root
);

    localparam int CntW = $clog2(DistW);

    logic               r_busy;
    logic               r_done;
    logic [CntW-1:0]    r_cnt;
    logic [2*DistW-1:0] r_x;
    logic [DistW+1:0]   r_rem;
    logic [DistW-1:0]   r_root;

    logic [DistW+3:0]   rem_sh;
    logic [DistW+3:0]   trial;
    logic               ge;

    // One result bit per cycle: bring down two radicand bits, try root*4+1
    always_comb begin
        rem_sh = {r_rem, r_x[2*DistW-1 -: 2]};
        trial  = {2'b00, r_root, 2'b01};
        ge     = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CntW'(DistW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift registers of the digit loop
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[2*DistW-3:0], 2'b00};
            r_rem  <= ge ? (DistW+2)'(rem_sh - trial) : (DistW+2)'(rem_sh);
            r_root <= {r_root[DistW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: src/nearest_segment_select.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------------
// segment  | i_valid / o_ready           | i_segment_id, i_group, i_start_x/y,
//          |                             | i_end_x/y, i_last
// result   | o_valid / i_ready           | o_selected_id, o_found, o_min_distance
// config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A segment of another group is passed over. A matching segment whose nearest point
// lies on an endpoint skips the 17-step bit-serial divider for t; one whose projection
// falls inside runs it. The 16-step bit-serial square root follows unless the squared
// distance overflows. A request with last set then loads the result register in S_FIN,
// and waits there while an earlier result has not been taken. Reset is synchronous,
// active low; it clears the query point, the group and the held selection.
module nearest_segment_select
    import nss_pkg::*;
#(
    parameter int GROUPS  = GROUPS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [IdW-1:0]           i_segment_id,
    input  logic [GroupW-1:0]        i_group,
    input  logic signed [CoordW-1:0] i_start_x,
    input  logic signed [CoordW-1:0] i_start_y,
    input  logic signed [CoordW-1:0] i_end_x,
    input  logic signed [CoordW-1:0] i_end_y,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [IdW-1:0]           o_selected_id,
    output logic                     o_found,
    output logic [DistW-1:0]         o_min_distance,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CfgIdxW-1:0]       i_cfg_index,
    input  logic [CoordW-1:0]        i_cfg_data
);

    localparam int KeepBits = (ID_BITS < IdW) ? ID_BITS : IdW;
    localparam logic [IdW-1:0] IdMask = IdW'((64'd1 << KeepBits) - 64'd1);
    localparam int DiffW = CoordW + 1;
    localparam int EW    = CoordW + 3;
    localparam int MulW  = EW + 1;
    localparam int ProdW = 2 * MulW;
    localparam int WideW = 2 * DiffW + 2;
    localparam int TW    = CoordW + 1;
    localparam int DivCntW = $clog2(TW);

    t_state r_state, n_state;

    // Configuration registers
    logic signed [CoordW-1:0] r_qx, r_qy;
    logic [GroupW-1:0]        r_agroup;

    // Captured request
    logic [IdW-1:0]            r_id;
    logic                      r_last;
    logic signed [CoordW-1:0]  r_sx, r_sy, r_endx, r_endy;
    logic signed [DiffW-1:0]   r_dx, r_dy, r_px, r_py;

    // Datapath
    logic signed [ProdW-1:0]   r_prod, r_acc;
    logic signed [WideW-1:0]   r_l2, r_dot;
    logic [WideW-2:0]          r_rem;
    logic [TW-1:0]             r_t;
    logic [DivCntW-1:0]        r_cnt;
    logic signed [EW-1:0]      r_ex, r_ey;
    logic [DistW-1:0]          r_dist;

    // Scan and result state
    logic [DistW-1:0] r_best;
    logic [IdW-1:0]   r_best_id, r_held_id;
    logic             r_hit, r_held_valid;
    logic             r_out_valid;
    logic [IdW-1:0]   r_out_id;
    logic             r_out_found;
    logic [DistW-1:0] r_out_dist;

    logic accept, match, slot_free;
    logic signed [MulW-1:0] mul_a, mul_b;
    logic [WideW-2:0] trial;
    logic ge;
    logic signed [ProdW-1:0] rnd;
    logic sqrt_start, sqrt_done;
    logic [DistW-1:0] sqrt_root;

    assign accept    = i_valid && o_ready;
    assign match     = (i_group == r_agroup) && (32'(i_group) < GROUPS);
    assign slot_free = !r_out_valid || i_ready;
    assign o_cfg_ready = 1'b1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (accept) n_state = match ? S_L2A : (i_last ? S_FIN : S_IDLE);
            S_L2A:    n_state = S_L2B;
            S_L2B:    n_state = S_DOTA;
            S_DOTA:   n_state = S_DOTB;
            S_DOTB:   n_state = S_DOT;
            S_DOT:    n_state = S_CHK;
            S_CHK:    n_state = (r_l2 == '0 || r_dot[WideW-1] || r_dot > r_l2) ? S_SQA : S_DIV;
            S_DIV:    if (r_cnt == DivCntW'(TW - 1)) n_state = S_PXA;
            S_PXA:    n_state = S_PXB;
            S_PXB:    n_state = S_PYA;
            S_PYA:    n_state = S_SQA;
            S_SQA:    n_state = S_SQB;
            S_SQB:    n_state = S_SUM;
            S_SUM:    n_state = S_RSTART;
            S_RSTART: n_state = (r_acc[ProdW-1:2*DistW] != '0) ? S_UPD : S_ROOT;
            S_ROOT:   if (sqrt_done) n_state = S_UPD;
            S_UPD:    n_state = r_last ? S_FIN : S_IDLE;
            S_FIN:    if (slot_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: multiplier operands, input ready and root start
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sqrt_start = 1'b0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE:   o_ready = 1'b1;
            S_L2A:    begin mul_a = MulW'(r_dx); mul_b = MulW'(r_dx); end
            S_L2B:    begin mul_a = MulW'(r_dy); mul_b = MulW'(r_dy); end
            S_DOTA:   begin mul_a = MulW'(r_px); mul_b = MulW'(r_dx); end
            S_DOTB:   begin mul_a = MulW'(r_py); mul_b = MulW'(r_dy); end
            S_PXA:    begin mul_a = MulW'({1'b0, r_t}); mul_b = MulW'(r_dx); end
            S_PXB:    begin mul_a = MulW'({1'b0, r_t}); mul_b = MulW'(r_dy); end
            S_SQA:    begin mul_a = MulW'(r_ex); mul_b = MulW'(r_ex); end
            S_SQB:    begin mul_a = MulW'(r_ey); mul_b = MulW'(r_ey); end
            S_RSTART: sqrt_start = (r_acc[ProdW-1:2*DistW] == '0);
            default:  ;
        endcase
    end

    // Divider step and projection rounding
    always_comb begin
        trial = (r_cnt == '0) ? r_rem : {r_rem[WideW-3:0], 1'b0};
        ge    = trial >= r_l2[WideW-2:0];
        rnd   = (r_prod + ProdW'(32768)) >>> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qx     <= '0;
            r_qy     <= '0;
            r_agroup <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QUERY_X:      r_qx     <= i_cfg_data;
                CFG_QUERY_Y:      r_qy     <= i_cfg_data;
                CFG_ACTIVE_GROUP: r_agroup <= i_cfg_data[GroupW-1:0];
                default:          ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: if (accept) begin
                r_id   <= i_segment_id & IdMask;
                r_last <= i_last;
                r_sx   <= i_start_x;
                r_sy   <= i_start_y;
                r_endx <= i_end_x;
                r_endy <= i_end_y;
                r_dx   <= DiffW'(i_end_x) - DiffW'(i_start_x);
                r_dy   <= DiffW'(i_end_y) - DiffW'(i_start_y);
                r_px   <= DiffW'(r_qx) - DiffW'(i_start_x);
                r_py   <= DiffW'(r_qy) - DiffW'(i_start_y);
            end
            S_L2B:  r_acc <= r_prod;
            S_DOTA: r_l2  <= WideW'(r_acc + r_prod);
            S_DOTB: r_acc <= r_prod;
            S_DOT:  r_dot <= WideW'(r_acc + r_prod);
            S_CHK: begin
                r_rem <= r_dot[WideW-2:0];
                r_t   <= '0;
                r_cnt <= '0;
                if (r_l2 == '0 || r_dot[WideW-1]) begin
                    r_ex <= EW'(r_px);
                    r_ey <= EW'(r_py);
                end else begin
                    r_ex <= EW'(r_qx) - EW'(r_endx);
                    r_ey <= EW'(r_qy) - EW'(r_endy);
                end
            end
            S_DIV: begin
                r_rem <= ge ? trial - r_l2[WideW-2:0] : trial;
                r_t   <= {r_t[TW-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            S_PXB: r_ex <= EW'(ProdW'(r_qx) - ProdW'(r_sx) - rnd);
            S_PYA: r_ey <= EW'(ProdW'(r_qy) - ProdW'(r_sy) - rnd);
            S_SQB: r_acc <= r_prod;
            S_SUM: r_acc <= r_acc + r_prod;
            S_RSTART: r_dist <= DIST_MAX;
            S_ROOT: if (sqrt_done) r_dist <= sqrt_root;
            default: ;
        endcase
    end

    // Scan best, held selection and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best       <= DIST_MAX;
            r_best_id    <= '0;
            r_hit        <= 1'b0;
            r_held_id    <= '0;
            r_held_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_UPD && (!r_hit || r_dist < r_best)) begin
                r_best    <= r_dist;
                r_best_id <= r_id;
                r_hit     <= 1'b1;
            end
            if (r_state == S_FIN && slot_free) begin
                r_out_valid <= 1'b1;
                r_out_id    <= r_hit ? r_best_id : r_held_id;
                r_out_found <= r_hit || r_held_valid;
                r_out_dist  <= r_best;
                if (r_hit) begin
                    r_held_id    <= r_best_id;
                    r_held_valid <= 1'b1;
                end
                r_best    <= DIST_MAX;
                r_best_id <= '0;
                r_hit     <= 1'b0;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_selected_id  = r_out_id;
    assign o_found        = r_out_found;
    assign o_min_distance = r_out_dist;

    nss_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (r_acc[2*DistW-1:0]),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    a_rem_below_l2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem <= r_l2[WideW-2:0]))
        else $error("divider remainder exceeds segment length");

    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PXA) |-> (r_t <= TW'(65536)))
        else $error("projection parameter out of range");

    a_root_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sqrt_done |-> (r_state == S_ROOT))
        else $error("root finished outside its wait state");

    a_scan_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && slot_free) |=> (!r_hit && r_best == DIST_MAX && r_out_valid))
        else $error("scan not restarted after result");

endmodule

FILE: bench/nearest_segment_select_tb.sv
module nearest_segment_select_tb;
    import nss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 20000;
    localparam int SettleCycles = 80;

    typedef struct packed {
        logic [IdW-1:0]    selected_id;
        logic              found;
        logic [DistW-1:0]  min_distance;
    } t_selection;

    // Nearest-segment scoreboard: tracks scan state and queues selections
    class nearest_scoreboard;
        logic signed [CoordW-1:0] qx, qy;
        logic [GroupW-1:0]        grp_sel;
        logic [DistW-1:0]         best_dist;
        logic [IdW-1:0]           best_seg;
        bit                       hit;
        logic [IdW-1:0]           held_id;
        bit                       held_ok;
        t_selection               pending[$];
        int                       errors;

        function new();
            qx = 0; qy = 0; grp_sel = 0;
            best_dist = DIST_MAX; best_seg = 0; hit = 0;
            held_id = 0; held_ok = 0; errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CoordW-1:0] data);
            case (idx)
                CFG_QUERY_X:      qx = data;
                CFG_QUERY_Y:      qy = data;
                CFG_ACTIVE_GROUP: grp_sel = data[GroupW-1:0];
                default: ;
            endcase
        endfunction

        static function logic [DistW-1:0] length_of(longint x, longint y);
            longint unsigned s, r, b;
            s = x * x + y * y;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b >>= 2;
            while (b != 0) begin
                if (s >= r + b) begin
                    s -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return (r > 65535) ? DIST_MAX : r[DistW-1:0];
        endfunction

        static function longint round_q16(longint v);
            longint w;
            w = v + 32768;
            if (w >= 0) return w >>> 16;
            return -((-w + 65535) >>> 16);
        endfunction

        function logic [DistW-1:0] point_to_segment(longint sx, longint sy,
                                                     longint ex, longint ey);
            longint dx, dy, px, py, l2, dot, t, prx, pry;
            dx = ex - sx; dy = ey - sy;
            px = longint'(qx) - sx; py = longint'(qy) - sy;
            l2 = dx * dx + dy * dy;
            if (l2 == 0) return length_of(px, py);
            dot = px * dx + py * dy;
            if (dot < 0) return length_of(px, py);
            if (dot > l2) return length_of(longint'(qx) - ex, longint'(qy) - ey);
            t = (dot << 16) / l2;
            prx = sx + round_q16(t * dx);
            pry = sy + round_q16(t * dy);
            return length_of(longint'(qx) - prx, longint'(qy) - pry);
        endfunction

        // Note an accepted segment request
        function void note_segment(logic [IdW-1:0] id, logic [GroupW-1:0] grp,
                                   logic signed [CoordW-1:0] sx, logic signed [CoordW-1:0] sy,
                                   logic signed [CoordW-1:0] ex, logic signed [CoordW-1:0] ey,
                                   logic last);
            logic [DistW-1:0] d;
            t_selection r;
            if (grp == grp_sel && int'(grp) < GROUPS_DEF) begin
                d = point_to_segment(sx, sy, ex, ey);
                if (!hit || d < best_dist) begin
                    best_dist = d; best_seg = id; hit = 1;
                end
            end
            if (last) begin
                if (hit) begin
                    held_id = best_seg; held_ok = 1;
                end
                r.selected_id = held_id;
                r.found = held_ok;
                r.min_distance = hit ? best_dist : DIST_MAX;
                pending.push_back(r);
                best_dist = DIST_MAX; best_seg = 0; hit = 0;
            end
        endfunction

        // Check an accepted selection against the oldest expectation
        function void check_selection(t_selection got);
            t_selection exp_r;
            if (pending.size() == 0) begin
                $error("unexpected selection id=%0d", got.selected_id);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.selected_id !== exp_r.selected_id) begin
                $error("selected_id exp %0d got %0d", exp_r.selected_id, got.selected_id);
                errors++;
            end
            if (got.found !== exp_r.found) begin
                $error("found exp %0d got %0d", exp_r.found, got.found);
                errors++;
            end
            if (got.min_distance !== exp_r.min_distance) begin
                $error("min_distance exp %0d got %0d", exp_r.min_distance,
                       got.min_distance);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_valid, o_ready, i_last;
    logic [IdW-1:0] i_segment_id;
    logic [GroupW-1:0] i_group;
    logic signed [CoordW-1:0] i_start_x, i_start_y, i_end_x, i_end_y;
    logic o_valid, i_ready, o_found;
    logic [IdW-1:0] o_selected_id;
    logic [DistW-1:0] o_min_distance;
    logic i_cfg_valid, o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [CoordW-1:0] i_cfg_data;

    nearest_scoreboard sb;
    bit calm;
    int quiet_cycles;

    nearest_segment_select DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 0; i_valid = 0; i_ready = 0; i_cfg_valid = 0;
        i_segment_id = 0; i_group = 0; i_last = 0;
        i_start_x = 0; i_start_y = 0; i_end_x = 0; i_end_y = 0;
        i_cfg_index = 0; i_cfg_data = 0;
        calm = 0; quiet_cycles = 0;
        sb = new();
    end

    // Check selections and watch for a stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_selection('{o_selected_id, o_found, o_min_distance});
            if ((o_valid && i_ready) || (i_valid && o_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit) begin
                $display("nearest_segment_select: mismatch");
                $finish;
            end
        end
    end

    // Result-side backpressure
    always @(negedge i_clk)
        i_ready <= calm || ($urandom_range(99) >= 25);

    task automatic write_reg(t_cfg_idx idx, logic [CoordW-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send_segment(logic [IdW-1:0] id, logic [GroupW-1:0] grp,
                                logic [CoordW-1:0] sx, logic [CoordW-1:0] sy,
                                logic [CoordW-1:0] ex, logic [CoordW-1:0] ey, logic last);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 25) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_segment_id <= id; i_group <= grp; i_last <= last;
        i_start_x <= sx; i_start_y <= sy; i_end_x <= ex; i_end_y <= ey;
        do @(posedge i_clk); while (!o_ready);
        sb.note_segment(id, grp, sx, sy, ex, ey, last);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    function automatic logic [CoordW-1:0] pick_coord();
        case ($urandom_range(9))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return CoordW'($urandom());
            default: return CoordW'($urandom_range(32768) - 16384);
        endcase
    endfunction

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Random scan: mostly active-group segments, ends on last
    task automatic random_scan();
        int n;
        logic [CoordW-1:0] sx;
        n = $urandom_range(6, 1);
        for (int k = 0; k < n; k++) begin
            sx = pick_coord();
            send_segment(IdW'($urandom()),
                         ($urandom_range(3) == 0) ? GroupW'($urandom()) : sb.grp_sel,
                         sx, pick_coord(),
                         ($urandom_range(7) == 0) ? sx : pick_coord(),
                         pick_coord(), k == n - 1);
        end
    endtask

    initial begin
        int sent;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: no match, degenerate, before start, beyond end, interior, tie
        send_segment(12'd5, 2'd1, 16'sd0, 16'sd0, 16'sd100, 16'sd0, 1'b1);
        send_segment(12'd7, 2'd0, 16'sd300, 16'sd400, 16'sd300, 16'sd400, 1'b0);
        send_segment(12'd8, 2'd0, 16'sd100, 16'sd0, 16'sd200, 16'sd0, 1'b0);
        send_segment(12'd9, 2'd0, -16'sd200, 16'sd0, -16'sd100, 16'sd0, 1'b0);
        send_segment(12'd10, 2'd0, -16'sd50, 16'sd60, 16'sd50, 16'sd60, 1'b0);
        send_segment(12'd11, 2'd0, -16'sd50, -16'sd60, 16'sd50, -16'sd60, 1'b1);
        send_segment(12'hFFF, 2'd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_segment(12'd0, 2'd3, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1);
        send_segment(12'd1, 2'd2, 16'sd16384, -16'sd16384, -16'sd16384, 16'sd16384, 1'b1);
        drain();

        write_reg(CFG_QUERY_X, 16'sd16384);
        write_reg(CFG_QUERY_Y, -16'sd16384);
        write_reg(CFG_ACTIVE_GROUP, 16'd3);
        write_reg(t_cfg_idx'(2'd3), 16'hFFFF);
        send_segment(12'd20, 2'd3, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1);
        send_segment(12'd21, 2'd3, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, 1'b1);
        send_segment(12'd22, 2'd3, 16'sd0, 16'sd0, 16'sd16384, -16'sd16384, 1'b1);
        drain();

        // Random phases with fresh settings
        sent = 0;
        for (int ph = 0; sent < 700; ph++) begin
            calm = (ph == 3);
            write_reg(CFG_QUERY_X, pick_coord());
            write_reg(CFG_QUERY_Y, pick_coord());
            write_reg(CFG_ACTIVE_GROUP, CoordW'($urandom_range(3)));
            repeat (40) begin
                random_scan();
                sent += 4;
            end
            drain();
        end

        if (sb.errors == 0)
            $display("nearest_segment_select: match");
        else
            $display("nearest_segment_select: mismatch");
        $finish;
    end
endmodule

FILE: files.f
src/nss_pkg.sv
src/nss_sqrt.sv
src/nearest_segment_select.sv
bench/nearest_segment_select_tb.sv
